FILE: design/slrf_pkg.sv
// ----------------------------------------------------------------------------
// slrf_pkg
// Shared types, codes and seven-segment glyphs for the segment LCD
// reading formatter.
// ----------------------------------------------------------------------------
package slrf_pkg;

    // event kinds carried in the input tuser
    typedef enum logic [2:0] {
        OP_HUMIDITY    = 3'd0,
        OP_TEMPERATURE = 3'd1,
        OP_BATTERY     = 3'd2,
        OP_BLINK_TICK  = 3'd3,
        OP_BLINK_STOP  = 3'd4
    } op_t;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HUMIDITY_LIMIT  = 2'd0;
    localparam logic [1:0] REG_TEMP_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] REG_TEMP_LOW_LIMIT  = 2'd2;

    // register reset values
    localparam logic [13:0] HumidityLimitReset = 14'd10000;
    localparam logic [13:0] TempHighLimitReset = 14'd10000;
    localparam logic [14:0] TempLowLimitReset  = 15'h58F0;   // -10000

    // smallest magnitude the four digits cannot show
    localparam logic [16:0] DigitSpan = 17'd10000;

    // glyph bits
    localparam logic [7:0] SegE    = 8'hF1;
    localparam logic [7:0] DotBit  = 8'h08;
    localparam logic [7:0] MinusBit = 8'h08;
    localparam logic [7:0] NetBits = 8'h0F;
    localparam logic [7:0] BarBits = 8'hF0;

    // reciprocal constants for the digit split, valid for values below 10000
    localparam logic [27:0] Recip1000 = 28'd8389;   // shift 23
    localparam logic [27:0] Recip100  = 28'd5243;   // shift 19
    localparam logic [27:0] Recip10   = 28'd6554;   // shift 16

    // seven-segment code of a decimal digit
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0: code = 8'hD7;
            4'd1: code = 8'h06;
            4'd2: code = 8'hE3;
            4'd3: code = 8'hA7;
            4'd4: code = 8'h36;
            4'd5: code = 8'hB5;
            4'd6: code = 8'hF5;
            4'd7: code = 8'h07;
            4'd8: code = 8'hF7;
            4'd9: code = 8'hB7;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

FILE: design/segment_lcd_reading_formatter.sv
// ----------------------------------------------------------------------------
// segment_lcd_reading_formatter
// Keeps an eight-byte segment LCD image and redraws it for each event.
// ----------------------------------------------------------------------------
// Each accepted transfer is one event (humidity, temperature, battery, blink
// tick or blink stop, kind in s_tuser) and yields exactly one result transfer
// with the whole updated image and an out-of-limit status. The block takes a
// new event every cycle while s_tready is high. An accepted event passes
// through two registers, the input register and the image/result register,
// with a single pass of digit split and glyph lookup in between. Backpressure
// on the result side holds the result and fills the input register, then
// drops s_tready. Limits are to be written through the APB port only while
// the block is idle; the block itself does not enforce this. No clearing
// pass is needed after reset.
module segment_lcd_reading_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    // event channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [16:0] value (signed), rest zero
    input  logic [2:0]  s_tuser,    // [2:0] op
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] segment_image, byte k at 8k+7:8k
    output logic        m_tuser,    // [0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [13:0] hum_limit_reg;
    logic [13:0] temp_high_reg;
    logic [14:0] temp_low_reg;
    logic        cfg_write;

    // pipeline registers
    logic               in_valid_reg;
    logic [2:0]         in_op_reg;
    logic signed [16:0] in_value_reg;
    logic               out_valid_reg;
    logic               status_reg;
    logic               status_next;
    logic               blink_reg;
    logic               blink_next;
    logic [7:0][7:0]    image_reg;
    logic [7:0][7:0]    image_next;
    logic               advance;

    // datapath
    logic signed [16:0] hum_lim_ext;
    logic signed [16:0] high_lim_ext;
    logic signed [16:0] low_lim_ext;
    logic               hum_err;
    logic               temp_err;
    logic [16:0]        abs_value;
    logic [13:0]        mag;
    logic [27:0]        prod1000;
    logic [27:0]        prod100;
    logic [27:0]        prod10;
    logic [4:0]         q1000;
    logic [8:0]         q100;
    logic [11:0]        q10;
    logic [8:0]         rem100;
    logic [11:0]        rem10;
    logic [13:0]        rem1;
    logic [3:0]         dig3;
    logic [3:0]         dig2;
    logic [3:0]         dig1;
    logic [3:0]         dig0;
    logic [7:0]         lead_code;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_limit_reg <= slrf_pkg::HumidityLimitReset;
            temp_high_reg <= slrf_pkg::TempHighLimitReset;
            temp_low_reg  <= slrf_pkg::TempLowLimitReset;
        end else if (cfg_write) begin
            case (paddr[3:2])
                slrf_pkg::REG_HUMIDITY_LIMIT:  hum_limit_reg <= pwdata[13:0];
                slrf_pkg::REG_TEMP_HIGH_LIMIT: temp_high_reg <= pwdata[13:0];
                slrf_pkg::REG_TEMP_LOW_LIMIT:  temp_low_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            slrf_pkg::REG_HUMIDITY_LIMIT:  prdata = {18'd0, hum_limit_reg};
            slrf_pkg::REG_TEMP_HIGH_LIMIT: prdata = {18'd0, temp_high_reg};
            slrf_pkg::REG_TEMP_LOW_LIMIT:  prdata = {{17{temp_low_reg[14]}}, temp_low_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: result register frees on take, input register behind it
    // ------------------------------------------------------------------
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_value_reg <= s_tdata[16:0];
        end
    end

    // ------------------------------------------------------------------
    // limit checks
    // ------------------------------------------------------------------
    assign hum_lim_ext  = {3'b000, hum_limit_reg};
    assign high_lim_ext = {3'b000, temp_high_reg};
    assign low_lim_ext  = {{2{temp_low_reg[14]}}, temp_low_reg};

    assign hum_err = in_value_reg[16] || (in_value_reg >= hum_lim_ext) ||
                     (in_value_reg >= $signed(slrf_pkg::DigitSpan));

    assign temp_err = (in_value_reg >= high_lim_ext) || (in_value_reg <= low_lim_ext) ||
                      (in_value_reg >= $signed(slrf_pkg::DigitSpan)) ||
                      (in_value_reg <= -$signed(slrf_pkg::DigitSpan));

    // ------------------------------------------------------------------
    // digit split by reciprocal multiplies, all four digits in parallel
    // ------------------------------------------------------------------
    assign abs_value = in_value_reg[16] ? 17'(-in_value_reg) : 17'(in_value_reg);
    assign mag       = abs_value[13:0];

    assign prod1000 = 28'(mag) * slrf_pkg::Recip1000;
    assign prod100  = 28'(mag) * slrf_pkg::Recip100;
    assign prod10   = 28'(mag) * slrf_pkg::Recip10;

    assign q1000 = prod1000[27:23];
    assign q100  = prod100[27:19];
    assign q10   = prod10[27:16];

    assign rem100 = q100 - 9'(q1000) * 9'd10;
    assign rem10  = q10 - 12'(q100) * 12'd10;
    assign rem1   = mag - 14'(q10) * 14'd10;

    assign dig3 = q1000[3:0];
    assign dig2 = rem100[3:0];
    assign dig1 = rem10[3:0];
    assign dig0 = rem1[3:0];

    // leading digit is blanked when zero
    assign lead_code = (dig3 == 4'd0) ? 8'h00 : slrf_pkg::seg_code(dig3);

    // ------------------------------------------------------------------
    // image update for the event in the input register
    // ------------------------------------------------------------------
    always_comb begin
        image_next  = image_reg;
        status_next = 1'b0;
        blink_next  = blink_reg;
        case (in_op_reg)
            slrf_pkg::OP_HUMIDITY: begin
                if (hum_err) begin
                    image_next[4] = slrf_pkg::SegE;
                    image_next[5] = slrf_pkg::seg_code(4'd1);
                    image_next[6] = slrf_pkg::DotBit;
                    status_next   = 1'b1;
                end else begin
                    image_next[4] = lead_code;
                    image_next[5] = slrf_pkg::seg_code(dig2) | slrf_pkg::DotBit;
                    image_next[6] = slrf_pkg::seg_code(dig1) | slrf_pkg::DotBit;
                end
            end
            slrf_pkg::OP_TEMPERATURE: begin
                if (temp_err) begin
                    image_next[0] = slrf_pkg::SegE;
                    image_next[1] = slrf_pkg::seg_code(4'd1);
                    image_next[2] = 8'h00;
                    image_next[3] = slrf_pkg::DotBit;
                    status_next   = 1'b1;
                end else begin
                    if (in_value_reg[16]) begin
                        image_next[4] = image_reg[4] | slrf_pkg::MinusBit;
                    end else begin
                        image_next[4] = image_reg[4] & ~slrf_pkg::MinusBit;
                    end
                    image_next[0] = lead_code;
                    image_next[1] = slrf_pkg::seg_code(dig2) | slrf_pkg::DotBit;
                    image_next[2] = slrf_pkg::seg_code(dig1);
                    image_next[3] = slrf_pkg::seg_code(dig0) | slrf_pkg::DotBit;
                end
            end
            slrf_pkg::OP_BATTERY: begin
                // zero or below lights the whole bar
                image_next[7] = image_reg[7] | slrf_pkg::BarBits;
                if (in_value_reg > 17'sd80) begin
                    image_next[7] = image_reg[7] | slrf_pkg::BarBits;
                end else if (in_value_reg > 17'sd50) begin
                    image_next[7] = (image_reg[7] | slrf_pkg::BarBits) & 8'hBF;
                end else if (in_value_reg > 17'sd20) begin
                    image_next[7] = (image_reg[7] | slrf_pkg::BarBits) & 8'h9F;
                end else if (in_value_reg > 17'sd0) begin
                    image_next[7] = (image_reg[7] | slrf_pkg::BarBits) & 8'h1F;
                end
            end
            slrf_pkg::OP_BLINK_TICK: begin
                if (!blink_reg) begin
                    image_next[7] = image_reg[7] | slrf_pkg::NetBits;
                end else begin
                    image_next[7] = image_reg[7] & ~slrf_pkg::NetBits;
                end
                blink_next = !blink_reg;
            end
            slrf_pkg::OP_BLINK_STOP: begin
                if (in_value_reg != 17'sd0) begin
                    image_next[7] = image_reg[7] | slrf_pkg::NetBits;
                end else begin
                    image_next[7] = image_reg[7] & ~slrf_pkg::NetBits;
                end
            end
            default: ;
        endcase
    end

    // image doubles as the result payload: it only moves when the slot frees
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_reg  <= '0;
            blink_reg  <= 1'b0;
            status_reg <= 1'b0;
        end else if (advance && in_valid_reg) begin
            image_reg  <= image_next;
            blink_reg  <= blink_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = image_reg;
    assign m_tuser  = status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a flagged result always carries an E1 field in one of the readouts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[55:32] == 24'h0806F1) || (m_tdata[31:0] == 32'h080006F1))
        else $error("status set without an E1 readout");

    // an event in the input register moves on whenever the result slot frees
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> m_tvalid)
        else $error("event lost between input and result register");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the image stays put while a result waits to be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(image_reg) && $stable(blink_reg))
        else $error("image changed under a stalled result");

endmodule
